FILE: rtl/lpd_pkg.sv
// shared types, constants and fixed-point helpers for the legendre evaluator
`default_nettype none
package lpd_pkg;

	// digit width of the serial multipliers
	localparam int DIG = 16;
	// width of the small step constants m, m+1, 2m+1
	localparam int KW = 7;
	localparam int WORK_FRAC = 30;
	localparam int RECIP_BITS = 32;
	localparam int RECIP_W = 33;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] P_ONE = 64'sh0000_0000_4000_0000;

	// value with its saturation flag
	typedef struct packed {
		logic sat;
		logic signed [63:0] val;
	} sval_t;

	// recurrence state handed from one step to the next
	typedef struct packed {
		logic [KW-1:0] n;
		logic signed [63:0] xm;
		logic signed [63:0] p;
		logic signed [63:0] q;
		logic signed [63:0] t;
		logic sat;
		logic mapf;
	} tok_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		logic [63:0] r;
		r = v[63] ? (64'd0 - v) : v;
		return r;
	endfunction

	// magnitude shifted right with rounding half away from zero, signed 64-bit saturation
	function automatic sval_t round_sat(input logic [127:0] mag, input logic neg,
		input int unsigned sh);
		logic [128:0] sum;
		logic [128:0] q;
		sval_t r;
		sum = {1'b0, mag};
		if (sh != 0) begin
			sum = sum + (129'd1 << (sh - 1));
		end
		q = sum >> sh;
		if (neg) begin
			r.sat = (q > 129'h8000_0000_0000_0000);
			r.val = r.sat ? S64_MIN : $signed(64'd0 - q[63:0]);
		end else begin
			r.sat = (q > 129'h7FFF_FFFF_FFFF_FFFF);
			r.val = r.sat ? S64_MAX : $signed(q[63:0]);
		end
		return r;
	endfunction

	function automatic sval_t sadd64(input logic signed [63:0] a, input logic signed [63:0] b);
		logic [64:0] s;
		sval_t r;
		s = {a[63], a} + {b[63], b};
		r.sat = (s[64] != s[63]);
		r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : $signed(s[63:0]);
		return r;
	endfunction

	function automatic sval_t ssub64(input logic signed [63:0] a, input logic signed [63:0] b);
		logic [64:0] s;
		sval_t r;
		s = {a[63], a} - {b[63], b};
		r.sat = (s[64] != s[63]);
		r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : $signed(s[63:0]);
		return r;
	endfunction

	// signed value times a small non-negative constant, saturated to 64 bits
	function automatic sval_t smul_k(input logic signed [63:0] a, input logic [KW-1:0] k);
		logic signed [71:0] p;
		sval_t r;
		p = $signed({{8{a[63]}}, a}) * $signed({65'd0, k});
		r.sat = !((p[71:63] == 9'h000) || (p[71:63] == 9'h1FF));
		r.val = r.sat ? (p[71] ? S64_MIN : S64_MAX) : $signed(p[63:0]);
		return r;
	endfunction

	// clamp to a signed range of w bits
	function automatic sval_t clamp_w(input logic signed [63:0] v, input int unsigned w);
		logic signed [63:0] hi;
		sval_t r;
		hi = S64_MAX >>> (64 - w);
		r.sat = 1'b0;
		r.val = v;
		if (v > hi) begin
			r.sat = 1'b1;
			r.val = hi;
		end else if (v < ~hi) begin
			r.sat = 1'b1;
			r.val = ~hi;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/lpd_if.sv
// request and result channel interfaces of the legendre evaluator
`default_nettype none
interface lpd_in_if;
	logic valid;
	logic ready;
	logic [4:0] degree;
	logic signed [31:0] point;
	modport source (output valid, degree, point, input ready);
	modport sink (input valid, degree, point, output ready);
endinterface

interface lpd_out_if #(parameter int OUT_WIDTH = 48);
	logic valid;
	logic ready;
	logic signed [OUT_WIDTH-1:0] poly_value;
	logic signed [OUT_WIDTH-1:0] poly_slope;
	logic overflow;
	modport source (output valid, poly_value, poly_slope, overflow, input ready);
	modport sink (input valid, poly_value, poly_slope, overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/lpd_cell.sv
// one recurrence step: digit-serial products, step constants and reciprocal scale
`default_nettype none
module lpd_cell #(
	parameter int STEP = 0,
	parameter int OUT_WIDTH = 48
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  lpd_pkg::tok_t tok_in,
	output logic out_valid,
	output lpd_pkg::tok_t tok_out
);
	localparam int DIG = lpd_pkg::DIG;
	localparam int KW = lpd_pkg::KW;
	localparam int ND = (OUT_WIDTH + DIG - 1) / DIG;
	localparam int NDR = (lpd_pkg::RECIP_W + DIG - 1) / DIG;
	localparam int NDM = (ND > NDR) ? ND : NDR;
	localparam int RW = NDM * DIG;
	localparam int SW = ND * DIG;
	localparam int AW = 64 + RW;
	localparam int BW = OUT_WIDTH + SW;
	localparam int CW = $clog2(NDM);
	localparam int DIV = STEP + 1;
	localparam logic [KW-1:0] K_ODD = KW'(2 * STEP + 1);
	localparam logic [KW-1:0] K_M = KW'(STEP);
	localparam logic [KW-1:0] K_NEXT = KW'(STEP + 1);
	localparam logic [63:0] RECIP = ((64'd1 << lpd_pkg::RECIP_BITS) + 64'(DIV / 2)) / 64'(DIV);
	localparam logic [RW-1:0] RECIP_PAD = RW'(RECIP) << (RW - NDR * DIG);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_FIX1 = 3'd2;
	localparam logic [2:0] S_FIX2 = 3'd3;
	localparam logic [2:0] S_FIX3 = 3'd4;
	localparam logic [2:0] S_MUL2 = 3'd5;
	localparam logic [2:0] S_FIX4 = 3'd6;

	logic [2:0] state_q;
	logic [CW-1:0] cnt_q;
	logic vout_q;
	lpd_pkg::tok_t out_tok_q;

	logic [KW-1:0] n_q;
	logic signed [63:0] xm_q, r_q, t_q;
	logic sat_q, mapf_q;
	logic [63:0] amag_q;
	logic [OUT_WIDTH-1:0] bmag_q;
	logic nega_q, negb_q;
	logic [RW-1:0] rdig_q;
	logic [SW-1:0] sdig_q;
	logic [AW-1:0] acca_q;
	logic [BW-1:0] accb_q;
	logic signed [63:0] a_q, d_q, b_q, c_q, e_q, qn_q;

	logic [63:0] xin_mag, rin_mag, sin_mag;
	logic [63+DIG:0] proda;
	logic [OUT_WIDTH+DIG-1:0] prodb;
	lpd_pkg::sval_t a_res, d_res, b_res, c_res, e_res, num_res, qs_res, qc_res, pr_res, pc_res;

	always_comb begin
		xin_mag = lpd_pkg::mag64(tok_in.xm);
		rin_mag = lpd_pkg::mag64(tok_in.p);
		sin_mag = lpd_pkg::mag64(tok_in.q);
		proda = amag_q * rdig_q[RW-1 -: DIG];
		prodb = bmag_q * sdig_q[SW-1 -: DIG];
		a_res = lpd_pkg::round_sat(128'(acca_q), nega_q, lpd_pkg::WORK_FRAC);
		d_res = lpd_pkg::round_sat(128'(accb_q), negb_q, lpd_pkg::WORK_FRAC);
		b_res = lpd_pkg::smul_k(a_q, K_ODD);
		c_res = lpd_pkg::smul_k(t_q, K_M);
		e_res = lpd_pkg::smul_k(r_q, K_NEXT);
		num_res = lpd_pkg::ssub64(b_q, c_q);
		qs_res = lpd_pkg::sadd64(d_q, e_q);
		qc_res = lpd_pkg::clamp_w(qs_res.val, OUT_WIDTH);
		pr_res = lpd_pkg::round_sat(128'(acca_q), nega_q, lpd_pkg::RECIP_BITS);
		pc_res = lpd_pkg::clamp_w(pr_res.val, OUT_WIDTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			vout_q <= 1'b0;
		end else begin
			vout_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (tok_in.n > K_M) begin
							state_q <= S_MUL1;
							cnt_q <= CW'(ND - 1);
						end else begin
							vout_q <= 1'b1;
						end
					end
				end
				S_MUL1: begin
					if (cnt_q == '0) begin
						state_q <= S_FIX1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIX1: state_q <= S_FIX2;
				S_FIX2: state_q <= S_FIX3;
				S_FIX3: begin
					state_q <= S_MUL2;
					cnt_q <= CW'(NDR - 1);
				end
				S_MUL2: begin
					if (cnt_q == '0) begin
						state_q <= S_FIX4;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIX4: begin
					state_q <= S_IDLE;
					vout_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					// steps past the degree just hand the state on
					out_tok_q <= tok_in;
					n_q <= tok_in.n;
					xm_q <= tok_in.xm;
					r_q <= tok_in.p;
					t_q <= tok_in.t;
					sat_q <= tok_in.sat;
					mapf_q <= tok_in.mapf;
					amag_q <= xin_mag;
					bmag_q <= OUT_WIDTH'(xin_mag);
					nega_q <= tok_in.xm[63] ^ tok_in.p[63];
					negb_q <= tok_in.xm[63] ^ tok_in.q[63];
					rdig_q <= RW'(rin_mag) << (RW - SW);
					sdig_q <= SW'(sin_mag);
					acca_q <= '0;
					accb_q <= '0;
				end
			end
			S_MUL1: begin
				acca_q <= (acca_q << DIG) + AW'(proda);
				accb_q <= (accb_q << DIG) + BW'(prodb);
				rdig_q <= rdig_q << DIG;
				sdig_q <= sdig_q << DIG;
			end
			S_FIX1: begin
				a_q <= a_res.val;
				d_q <= d_res.val;
				sat_q <= sat_q | a_res.sat | d_res.sat;
			end
			S_FIX2: begin
				b_q <= b_res.val;
				c_q <= c_res.val;
				e_q <= e_res.val;
				sat_q <= sat_q | b_res.sat | c_res.sat | e_res.sat;
			end
			S_FIX3: begin
				qn_q <= qc_res.val;
				sat_q <= sat_q | num_res.sat | qs_res.sat | qc_res.sat;
				amag_q <= lpd_pkg::mag64(num_res.val);
				nega_q <= num_res.val[63];
				rdig_q <= RECIP_PAD;
				acca_q <= '0;
			end
			S_MUL2: begin
				acca_q <= (acca_q << DIG) + AW'(proda);
				rdig_q <= rdig_q << DIG;
			end
			S_FIX4: begin
				out_tok_q.n <= n_q;
				out_tok_q.xm <= xm_q;
				out_tok_q.p <= pc_res.val;
				out_tok_q.q <= qn_q;
				out_tok_q.t <= r_q;
				out_tok_q.sat <= sat_q | pr_res.sat | pc_res.sat;
				out_tok_q.mapf <= mapf_q;
			end
			default: ;
		endcase
	end

	assign out_valid = vout_q;
	assign tok_out = out_tok_q;

endmodule
`default_nettype wire

FILE: rtl/legendre_polynomial_with_derivative_core.sv
// top level of the legendre polynomial and derivative evaluator
`default_nettype none
// Evaluates the Legendre polynomial P_n and its derivative at a point x mapped onto the
// configured interval [a,b] as ((b+a)+(b-a)*x)/2. Registers: interval_low at byte 0,
// interval_high at byte 4, signed with IN_FRAC_BITS fraction bits, reset -1.0 and +1.0;
// write them only while no transaction is in flight. Results are signed with 30 fraction
// bits, saturated to OUT_WIDTH bits, and overflow flags any saturation for nonzero degree.
// Degree zero gives 1.0 and 0; degrees above MAX_DEGREE are clamped. One transaction is
// worked at a time: point mapping through registers s1, s2 and s3, then a row of MAX_DEGREE
// step units where every unit registers the token and each active step runs the 16-bit
// digit-serial multipliers of that step, then the result register. A finished result
// waits in an output register while the next transaction is already taken.
module legendre_polynomial_with_derivative_core #(
	parameter int MAX_DEGREE = 16,
	parameter int IN_FRAC_BITS = 29,
	parameter int OUT_WIDTH = 48
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	lpd_in_if.sink sample,
	lpd_out_if.source result
);
	localparam int KW = lpd_pkg::KW;
	localparam logic REG_LOW = 1'b0;
	localparam logic REG_HIGH = 1'b1;

	// configuration registers
	logic signed [31:0] low_q, high_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= 32'shE000_0000;
			high_q <= 32'sh2000_0000;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_LOW: low_q <= pwdata;
				REG_HIGH: high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LOW: prdata = low_q;
			REG_HIGH: prdata = high_q;
			default: prdata = '0;
		endcase
	end

	// control: one transaction in flight, a hold slot behind the result register
	logic busy_q;
	logic hold_valid_q;
	logic res_valid_q;
	logic accept, take;

	assign sample.ready = !busy_q && !hold_valid_q;
	assign accept = sample.valid && sample.ready;
	assign take = res_valid_q && result.ready;

	// point mapping, stage 1: span and base, span times point as magnitudes
	logic signed [32:0] span, base;
	logic [32:0] span_mag;
	logic [31:0] pt_mag;
	logic [KW-1:0] n_clamp;

	always_comb begin
		span = {high_q[31], high_q} - {low_q[31], low_q};
		base = {high_q[31], high_q} + {low_q[31], low_q};
		span_mag = span[32] ? (33'd0 - span) : span;
		pt_mag = sample.point[31] ? (32'd0 - sample.point) : sample.point;
		if (32'(sample.degree) > MAX_DEGREE) begin
			n_clamp = KW'(MAX_DEGREE);
		end else begin
			n_clamp = KW'(sample.degree);
		end
	end

	logic v_s1, v_s2, v_s3;
	logic [64:0] prod_s1;
	logic neg_s1;
	logic signed [63:0] base_s1;
	logic [KW-1:0] n_s1, n_s2;
	logic signed [63:0] sum_s2;
	logic mflag_s2;
	lpd_pkg::tok_t tok_s3;

	lpd_pkg::sval_t u_res, sum_res, xr_res, xc_res;

	always_comb begin
		u_res = lpd_pkg::round_sat(128'(prod_s1), neg_s1, 2 * IN_FRAC_BITS - 31);
		sum_res = lpd_pkg::sadd64(u_res.val, base_s1);
		// halving twice with rounding gives the mapped point
		xr_res = lpd_pkg::round_sat(128'(lpd_pkg::mag64(sum_s2)), sum_s2[63], 2);
		xc_res = lpd_pkg::clamp_w(xr_res.val, OUT_WIDTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= span_mag * pt_mag;
		neg_s1 <= span[32] ^ sample.point[31];
		base_s1 <= 64'(base) <<< (31 - IN_FRAC_BITS);
		n_s1 <= n_clamp;
		sum_s2 <= sum_res.val;
		mflag_s2 <= u_res.sat | sum_res.sat;
		n_s2 <= n_s1;
		tok_s3.n <= n_s2;
		tok_s3.xm <= xc_res.val;
		tok_s3.p <= lpd_pkg::P_ONE;
		tok_s3.q <= '0;
		tok_s3.t <= '0;
		tok_s3.sat <= 1'b0;
		tok_s3.mapf <= mflag_s2 | xr_res.sat | xc_res.sat;
	end

	// row of step units, unit i performs step m = i when the degree exceeds i
	logic chain_v [0:MAX_DEGREE];
	lpd_pkg::tok_t chain_t [0:MAX_DEGREE];

	assign chain_v[0] = v_s3;
	assign chain_t[0] = tok_s3;

	for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_step
		lpd_cell #(
			.STEP(i),
			.OUT_WIDTH(OUT_WIDTH)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(chain_v[i]),
			.tok_in(chain_t[i]),
			.out_valid(chain_v[i+1]),
			.tok_out(chain_t[i+1])
		);
	end

	logic fin;
	lpd_pkg::tok_t fin_t;
	logic fin_ovf;

	assign fin = chain_v[MAX_DEGREE];
	assign fin_t = chain_t[MAX_DEGREE];
	// the mapping clamp only counts when a step actually ran
	assign fin_ovf = (fin_t.n != '0) && (fin_t.sat || fin_t.mapf);

	logic signed [OUT_WIDTH-1:0] res_value_q, res_slope_q, hold_value_q, hold_slope_q;
	logic res_ovf_q, hold_ovf_q;
	logic load_res, load_hold, move_hold;

	assign load_res = fin && (!res_valid_q || take);
	assign load_hold = fin && res_valid_q && !take;
	assign move_hold = !fin && take && hold_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			res_valid_q <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (load_res || move_hold) begin
				res_valid_q <= 1'b1;
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
			if (load_hold) begin
				hold_valid_q <= 1'b1;
			end else if (move_hold) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_value_q <= fin_t.p[OUT_WIDTH-1:0];
			res_slope_q <= fin_t.q[OUT_WIDTH-1:0];
			res_ovf_q <= fin_ovf;
		end else if (move_hold) begin
			res_value_q <= hold_value_q;
			res_slope_q <= hold_slope_q;
			res_ovf_q <= hold_ovf_q;
		end
		if (load_hold) begin
			hold_value_q <= fin_t.p[OUT_WIDTH-1:0];
			hold_slope_q <= fin_t.q[OUT_WIDTH-1:0];
			hold_ovf_q <= fin_ovf;
		end
	end

	assign result.valid = res_valid_q;
	assign result.poly_value = res_value_q;
	assign result.poly_slope = res_slope_q;
	assign result.overflow = res_ovf_q;

endmodule
`default_nettype wire

FILE: tb/lpd_checker.sv
// result predictor and scoreboard for the legendre evaluator testbench
`timescale 1ns / 100ps
module lpd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic pready,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [4:0] in_degree,
	input wire logic signed [31:0] in_point,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [47:0] out_value,
	input wire logic signed [47:0] out_slope,
	input wire logic out_overflow,
	output int fail_count,
	output int outstanding
);
	localparam int MAX_DEG = 16;
	localparam int OUT_W = 48;
	localparam int REG_LOW = 0;
	localparam int REG_HIGH = 1;
	localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [47:0] value;
		logic signed [47:0] slope;
		logic overflow;
	} legendre_t;

	legendre_t pending_q[$];
	logic signed [31:0] bound_a, bound_b;

	// exact product, rounded half away from zero after a right shift; top bit flags saturation
	function automatic logic [64:0] fx_mul(input logic signed [63:0] x, input logic signed [63:0] y,
		input int sh);
		logic neg;
		logic [63:0] ux, uy;
		logic [128:0] pr, lim;
		neg = x[63] ^ y[63];
		ux = x[63] ? 64'd0 - x : x;
		uy = y[63] ? 64'd0 - y : y;
		pr = {65'd0, ux} * {65'd0, uy};
		if (sh > 0)
			pr = pr + (129'd1 << (sh - 1));
		pr = pr >> sh;
		lim = neg ? (129'd1 << 63) : ((129'd1 << 63) - 1);
		if (pr > lim)
			return {1'b1, neg ? S_MIN : S_MAX};
		return {1'b0, neg ? 64'd0 - pr[63:0] : pr[63:0]};
	endfunction

	function automatic logic [64:0] sat_sum(input logic signed [63:0] x, input logic signed [63:0] y,
		input logic sub);
		logic [64:0] s;
		s = sub ? {x[63], x} - {y[63], y} : {x[63], x} + {y[63], y};
		if (s[64] != s[63])
			return {1'b1, s[64] ? S_MIN : S_MAX};
		return {1'b0, s[63:0]};
	endfunction

	function automatic logic [64:0] clamp_out(input logic signed [63:0] x);
		logic signed [63:0] hi;
		hi = (64'sd1 <<< (OUT_W - 1)) - 1;
		if (x > hi)
			return {1'b1, hi};
		if (x < -hi - 1)
			return {1'b1, -hi - 1};
		return {1'b0, x};
	endfunction

	// maps the point onto [a,b] and runs the three-term recurrence
	function automatic legendre_t legendre_eval(input logic [4:0] deg, input logic signed [31:0] pt,
		input logic signed [31:0] lo_b, input logic signed [31:0] hi_b);
		logic signed [63:0] x, a, b, u, v, xm, p, q, t, r, s, num, recip, k;
		logic [64:0] w, w2;
		logic sat, map_sat;
		int n;
		legendre_t res;
		n = (deg > MAX_DEG) ? MAX_DEG : deg;
		x = pt;
		a = lo_b;
		b = hi_b;
		sat = 0;
		w = fx_mul(b - a, x, 27);
		sat |= w[64];
		u = w[63:0];
		v = (b + a) * 64'sd4;
		w = sat_sum(u, v, 1'b0);
		sat |= w[64];
		w = fx_mul(w[63:0], 64'sd1, 2);
		sat |= w[64];
		w = clamp_out(w[63:0]);
		map_sat = sat | w[64];
		xm = w[63:0];
		sat = 0;
		p = 64'sd1 <<< 30;
		q = 0;
		t = 0;
		for (int m = 0; m < n; m++) begin
			r = p;
			s = q;
			k = m + 1;
			recip = ((64'sd1 <<< 32) + k / 2) / k;
			w = fx_mul(xm, r, 30);
			sat |= w[64];
			w = fx_mul(w[63:0], 2 * m + 1, 0);
			sat |= w[64];
			w2 = fx_mul(t, m, 0);
			sat |= w2[64];
			w = sat_sum(w[63:0], w2[63:0], 1'b1);
			sat |= w[64];
			num = w[63:0];
			w = fx_mul(num, recip, 32);
			sat |= w[64];
			w = clamp_out(w[63:0]);
			sat |= w[64];
			p = w[63:0];
			w = fx_mul(xm, s, 30);
			sat |= w[64];
			w2 = fx_mul(r, k, 0);
			sat |= w2[64];
			w = sat_sum(w[63:0], w2[63:0], 1'b0);
			sat |= w[64];
			w = clamp_out(w[63:0]);
			sat |= w[64];
			q = w[63:0];
			t = r;
		end
		res.value = p[47:0];
		res.slope = q[47:0];
		res.overflow = (n > 0) && (sat || map_sat);
		return res;
	endfunction

	assign outstanding = pending_q.size();

	always @(posedge clk or negedge arst_n) begin
		legendre_t want;
		if (!arst_n) begin
			bound_a <= -32'sd536870912;
			bound_b <= 32'sd536870912;
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (int'(paddr >> 2))
					REG_LOW: bound_a <= pwdata;
					REG_HIGH: bound_b <= pwdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_q = {pending_q, legendre_eval(in_degree, in_point, bound_a, bound_b)};
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transaction: value %0d slope %0d ovf %0b",
							out_value, out_slope, out_overflow);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_q.pop_front();
					if (want.value !== out_value || want.slope !== out_slope ||
						want.overflow !== out_overflow) begin
						if (fail_count < 10)
							$display("mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
								want.value, want.slope, want.overflow,
								out_value, out_slope, out_overflow);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

FILE: tb/tb_legendre_polynomial_with_derivative_core.sv
// stimulus and verdict for the legendre polynomial and derivative evaluator
`timescale 1ns / 100ps
module tb_legendre_polynomial_with_derivative_core;
	// register byte addresses
	localparam logic [2:0] ADDR_LOW = 3'd0;
	localparam logic [2:0] ADDR_HIGH = 3'd4;
	// extra wait after the last expected result has been checked
	localparam int DRAIN_CYCLES = 250;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int RAND_PER_PHASE = 115;
	localparam int NUM_PHASES = 6;
	localparam logic signed [31:0] ONE_Q29 = 32'sd536870912;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	int fail_count, outstanding;
	int cycles;
	int sent;
	// no idling on either side while set
	logic quiet;

	lpd_in_if smp_if ();
	lpd_out_if #(.OUT_WIDTH(48)) res_if ();

	legendre_polynomial_with_derivative_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample(smp_if),
		.result(res_if)
	);

	lpd_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.in_valid(smp_if.valid),
		.in_ready(smp_if.ready),
		.in_degree(smp_if.degree),
		.in_point(smp_if.point),
		.out_valid(res_if.valid),
		.out_ready(res_if.ready),
		.out_value(res_if.poly_value),
		.out_slope(res_if.poly_slope),
		.out_overflow(res_if.overflow),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d transactions still expected",
				cycles, outstanding);
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stall bursts unless quiet
	always @(posedge clk) begin
		if (arst_n) begin
			if (quiet || $urandom_range(0, 5) != 0) begin
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				res_if.ready <= 1'b1;
			end
		end
	end

	// one configuration write: setup phase then access phase
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// hands one request transaction to the block, with an optional gap before it
	task automatic send_request(input logic [4:0] deg, input logic signed [31:0] pt);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			smp_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.degree <= deg;
		smp_if.point <= pt;
		@(posedge clk);
		while (!smp_if.ready) @(posedge clk);
		sent++;
	endtask

	// sender stops and waits for the block to drain completely
	task automatic drain_all();
		smp_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_point();
		case ($urandom_range(0, 6))
			0: return $signed($urandom_range(0, 1 << 30)) - ONE_Q29;
			1: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			3: return $urandom_range(0, 1) ? ONE_Q29 : -ONE_Q29;
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic logic [4:0] pick_degree();
		if ($urandom_range(0, 7) == 0)
			return 5'($urandom_range(17, 31));
		return 5'($urandom_range(0, 16));
	endfunction

	initial begin
		logic signed [31:0] lo_b, hi_b;
		cycles = 0;
		sent = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp_if.valid = 1'b0;
		smp_if.degree = '0;
		smp_if.point = '0;
		res_if.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset interval [-1,1], field extremes, degree zero, clamped degrees
		send_request(5'd0, 32'sd0);
		send_request(5'd0, 32'sh7FFF_FFFF);
		send_request(5'd1, 32'sd0);
		send_request(5'd1, ONE_Q29);
		send_request(5'd2, -ONE_Q29);
		send_request(5'd2, ONE_Q29 >>> 1);
		send_request(5'd3, 32'sh8000_0000);
		send_request(5'd16, ONE_Q29);
		send_request(5'd16, -ONE_Q29);
		send_request(5'd16, 32'sh7FFF_FFFF);
		send_request(5'd16, 32'sh8000_0000);
		send_request(5'd17, 32'sd1);
		send_request(5'd31, 32'sd12345);
		send_request(5'd31, -32'sd1);
		send_request(5'd8, 32'sh5555_5555);
		send_request(5'd8, 32'shAAAA_AAAA);
		send_request(5'd5, 32'sh0000_FFFF);
		send_request(5'd15, -32'sd268435456);
		drain_all();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// interval settings: [0,1], full extremes, reversed extremes, a equal b, random, then [-1,1]
			case (ph)
				0: begin lo_b = 32'sd0; hi_b = ONE_Q29; end
				1: begin lo_b = 32'sh8000_0000; hi_b = 32'sh7FFF_FFFF; end
				2: begin lo_b = 32'sh7FFF_FFFF; hi_b = 32'sh8000_0000; end
				3: begin lo_b = ONE_Q29 >>> 1; hi_b = ONE_Q29 >>> 1; end
				4: begin lo_b = $signed($urandom()); hi_b = $signed($urandom()); end
				default: begin lo_b = -ONE_Q29; hi_b = ONE_Q29; end
			endcase
			reg_write(ADDR_LOW, lo_b);
			reg_write(ADDR_HIGH, hi_b);
			// last phase runs at full rate on both sides
			quiet = (ph == NUM_PHASES - 1);
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				if (!quiet && i % 40 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				send_request(pick_degree(), pick_point());
			end
			drain_all();
		end

		$display("sent %0d request transactions over %0d interval settings", sent, NUM_PHASES + 1);
		$display("degrees 0..31, points at both extremes and within +-1.0, with random stalls");
		if (fail_count == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
